[src/s3g_pkg.sv]
// Shared types, sizes and register codes for the Sobel 3x3 gradient filter.
package s3g_pkg;

	// Largest supported image side, in pixels.
	localparam int MAX_WIDTH = 1024;

	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_WIDTH + 2);
	localparam int WID_W = 11;
	localparam int CFG_W = 11;
	localparam int IDX_W = 1;
	localparam int SUM_W = PIX_W + 4;
	localparam int LINE_W = 2 * PIX_W;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [IDX_W-1:0] REG_GRADIENT_DIRECTION = 1'b1;

	// Item kinds on the input tuser.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Gradient direction codes.
	localparam logic DIR_X = 1'b0;
	localparam logic DIR_Y = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [1:0] idx_t;
	typedef pix_t [2:0][2:0] win_t;

	// Fixed window rows and columns.
	localparam idx_t ROW_TOP = 2'd0;
	localparam idx_t ROW_MID = 2'd1;
	localparam idx_t ROW_BOT = 2'd2;
	localparam idx_t COL_MID = 2'd1;
	localparam idx_t COL_RIGHT = 2'd2;

	// Window taps that stand for the -1, 0 and +1 neighbors after edge replication.
	typedef struct packed {
		idx_t top;
		idx_t bot;
		idx_t lft;
		idx_t ctr;
	} sel_t;

	// Per-item control produced from the raster position at acceptance.
	typedef struct packed {
		logic emit;
		logic last;
		logic col_zero;
		logic [COL_W-1:0] col;
		sel_t sel;
	} ctl_flags_t;

endpackage

[src/s3g_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module s3g_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/s3g_ctl.sv]
// Configuration registers and raster position counters with per-item control flags.
module s3g_ctl import s3g_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic step,
	output ctl_flags_t flags,
	output logic dir
);

	logic [COL_W-1:0] wm1_q;
	logic dir_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] row_w;
	logic [ROW_W-1:0] row_w1;
	logic rr_first;
	logic rr_last;
	logic cc_first;
	logic [COL_W-1:0] wm1_new;

	// Width 0 acts as 1 and anything above the maximum is clamped.
	always_comb begin
		if (cfg_data == '0) begin
			wm1_new = '0;
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			wm1_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1_new = COL_W'(cfg_data - CFG_W'(1));
		end
	end

	assign row_w = ROW_W'(wm1_q) + ROW_W'(1);
	assign row_w1 = ROW_W'(wm1_q) + ROW_W'(2);

	// A column-zero item finishes the previous row, so its result sits two rows up.
	always_comb begin
		flags.col_zero = (col_q == '0);
		flags.col = col_q;
		flags.emit = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && !flags.col_zero);
		flags.last = flags.col_zero && (row_q == row_w1);
		rr_first = flags.col_zero ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
		rr_last = flags.col_zero ? (row_q == row_w1) : (row_q == row_w);
		cc_first = flags.col_zero ? (wm1_q == '0) : (col_q == COL_W'(1));
		flags.sel.top = rr_first ? ROW_MID : ROW_TOP;
		flags.sel.bot = rr_last ? ROW_MID : ROW_BOT;
		flags.sel.ctr = flags.col_zero ? COL_RIGHT : COL_MID;
		flags.sel.lft = cc_first ? flags.sel.ctr : flags.sel.ctr - idx_t'(1);
	end

	assign dir = dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= COL_W'(MAX_WIDTH - 1);
			dir_q <= DIR_X;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					wm1_q <= wm1_new;
					col_q <= '0;
					row_q <= '0;
				end
				REG_GRADIENT_DIRECTION: begin
					dir_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (step) begin
			if (flags.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == wm1_q) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

[src/s3g_grad.sv]
// Sobel kernel over the selected window taps, clamped to the pixel range.
module s3g_grad import s3g_pkg::*; (
	input win_t win,
	input sel_t sel,
	input logic dir,
	output pix_t grad
);

	logic signed [SUM_W-1:0] d0;
	logic signed [SUM_W-1:0] d1;
	logic signed [SUM_W-1:0] d2;
	logic signed [SUM_W-1:0] sum;

	function automatic logic signed [SUM_W-1:0] ext(input pix_t p);
		return $signed({{(SUM_W - PIX_W){1'b0}}, p});
	endfunction

	always_comb begin
		if (dir == DIR_X) begin
			d0 = ext(win[sel.top][COL_RIGHT]) - ext(win[sel.top][sel.lft]);
			d1 = ext(win[ROW_MID][COL_RIGHT]) - ext(win[ROW_MID][sel.lft]);
			d2 = ext(win[sel.bot][COL_RIGHT]) - ext(win[sel.bot][sel.lft]);
		end else begin
			d0 = ext(win[sel.bot][sel.lft]) - ext(win[sel.top][sel.lft]);
			d1 = ext(win[sel.bot][sel.ctr]) - ext(win[sel.top][sel.ctr]);
			d2 = ext(win[sel.bot][COL_RIGHT]) - ext(win[sel.top][COL_RIGHT]);
		end
		sum = d0 + (d1 <<< 1) + d2;
		if (sum < 0) begin
			grad = '0;
		end else if (sum > ext('1)) begin
			grad = '1;
		end else begin
			grad = sum[PIX_W-1:0];
		end
	end

endmodule

[src/sobel_3x3_gradient_filter.sv]
// Top level of the Sobel 3x3 gradient filter with line buffer, window and output register.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata: pixel_value; tuser: operation
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata: gradient_value; tlast: last_of_frame
//   cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// One request is accepted per clock while the output register is not stalled. A request
// waits in the input stage, where the line buffer RAM returns the two stored pixels of
// its column, and its result is then registered in the output register. Results lag
// their pixels by image width plus one requests, and the host follows the last pixel
// with that many drain requests.
// Reset clears the counters, the window and both valid flags; the line buffer is
// not cleared, since unwritten entries only feed taps that edge replication drops.
// A stalled result holds the input stage, and the input stage stalls the input side.
module sobel_3x3_gradient_filter import s3g_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata,   // [7:0] pixel_value
	input logic s_axis_tuser,         // [0] operation
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] gradient_value
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	ctl_flags_t flags;
	logic dir;
	logic accept;
	logic advance;

	// Input stage.
	logic valid_s1;
	ctl_flags_t flags_s1;
	pix_t pix_s1;
	logic fwd_hit_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	// Line buffer: upper store in the high byte, lower store in the low byte.
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_word;
	logic [LINE_W-1:0] ram_wdata;
	pix_t top_pix;
	pix_t mid_pix;

	win_t win_q;
	win_t win_shift;
	win_t win_calc;
	pix_t grad;

	logic out_valid_q;
	pix_t out_data_q;
	logic out_last_q;

	// The input stage moves on whenever the output register is free or being read.
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept = s_axis_tvalid && s_axis_tready;

	s3g_ctl u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step(accept),
		.flags(flags),
		.dir(dir)
	);

	// Each column is read when its request is accepted and written back when it leaves
	// the input stage, so both stores shift down by one row per visit.
	s3g_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we(advance),
		.waddr(flags_s1.col),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(flags.col),
		.rdata(ram_rdata)
	);

	// Consecutive requests use the same column with a one-pixel image or across a frame end;
	// the write of the older one lands in the very cycle the newer one reads; that data is forwarded.
	assign line_word = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign top_pix = line_word[LINE_W-1:PIX_W];
	assign mid_pix = line_word[PIX_W-1:0];
	assign ram_wdata = {mid_pix, pix_s1};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_shift[r][0] = win_q[r][1];
			win_shift[r][1] = win_q[r][2];
		end
		win_shift[ROW_TOP][COL_RIGHT] = top_pix;
		win_shift[ROW_MID][COL_RIGHT] = mid_pix;
		win_shift[ROW_BOT][COL_RIGHT] = pix_s1;
	end

	// A column-zero request closes the previous row, whose last pixel is centered in
	// the window before the new column shifts in.
	assign win_calc = flags_s1.col_zero ? win_q : win_shift;

	s3g_grad u_grad (
		.win(win_calc),
		.sel(flags_s1.sel),
		.dir(dir),
		.grad(grad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
			pix_s1 <= (s_axis_tuser == OP_DRAIN) ? '0 : s_axis_tdata;
			fwd_hit_s1 <= advance && (flags_s1.col == flags.col);
			fwd_data_s1 <= ram_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= win_shift;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= flags_s1.emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= grad;
			out_last_q <= flags_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_valid_q && out_last_q;

endmodule

[src/s3g_checker.sv]
// Port-level checks for the Sobel 3x3 gradient filter and their binding to the top level.
module s3g_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic m_axis_tlast
);

	// A held result keeps its value and frame marker.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// The input side only stalls behind a result that the sink refuses.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// The frame marker only comes with a result.
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tlast |-> m_axis_tvalid)
		else $error("tlast without tvalid");

	// While the input side is stalled and the sink refuses, the held result stays valid.
	a_no_ready_two: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped during stall");

endmodule

bind sobel_3x3_gradient_filter s3g_checker u_s3g_checker (.*);

[dv/sobel_result_checker.sv]
// Result checker for the Sobel 3x3 gradient filter: watches all channels, predicts and compares.
`timescale 1ns / 100ps

module sobel_result_checker import s3g_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [7:0] s_axis_tdata,   // [7:0] pixel_value
	input logic s_axis_tuser,         // [0] operation
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [7:0] m_axis_tdata,   // [7:0] gradient_value
	input logic m_axis_tlast,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output int mismatch_count,
	output int pending_count
);

	typedef struct packed {
		pix_t grad;
		logic last;
	} gradient_t;

	// Private copy of the filter state, kept in step with accepted requests.
	pix_t upper_line [MAX_WIDTH];
	pix_t lower_line [MAX_WIDTH];
	win_t window;
	int unsigned raster_pos;
	int unsigned side_reg;
	logic dir_reg;
	int unsigned results_seen;

	gradient_t pending_gradients [$];

	// Register values out of range behave as the nearest legal side.
	function automatic int unsigned active_side();
		if (side_reg == 0) return 1;
		if (side_reg > MAX_WIDTH) return MAX_WIDTH;
		return side_reg;
	endfunction

	function automatic int tap(input int r, input int c);
		return int'(window[r][c]);
	endfunction

	// Moves the window one column left and loads the new column from the line stores.
	function automatic void shift_column(input int unsigned col, input pix_t value);
		pix_t above;
		pix_t middle;
		above = upper_line[col];
		middle = lower_line[col];
		for (int r = 0; r < 3; r++) begin
			window[r][0] = window[r][1];
			window[r][1] = window[r][2];
		end
		window[0][2] = above;
		window[1][2] = middle;
		window[2][2] = value;
		upper_line[col] = middle;
		lower_line[col] = value;
	endfunction

	// Advances the private state by one request; returns 1 when a gradient comes out.
	function automatic logic predict_gradient(input logic op, input pix_t value,
			output gradient_t res);
		int unsigned side;
		int unsigned pos;
		int unsigned col;
		int unsigned lag;
		int unsigned m;
		int unsigned rr;
		int unsigned cc;
		int rt;
		int rb;
		int cl;
		int cen;
		int sum;
		logic emit;
		pix_t pix;
		side = active_side();
		pos = raster_pos;
		col = pos % side;
		lag = side + 1;
		pix = (op == OP_DRAIN) ? 8'd0 : value;
		emit = 1'b0;
		res = '0;
		// At column zero the result belongs to the previous row's last pixel, so the
		// window is read before the new column enters.
		if (col != 0) shift_column(col, pix);
		if (pos >= lag && pos - lag < side * side) begin
			m = pos - lag;
			rr = m / side;
			cc = m % side;
			cen = (col == 0) ? 2 : 1;
			// Edge replication: an outside neighbor takes the center tap instead.
			rt = (rr == 0) ? 1 : 0;
			rb = (rr == side - 1) ? 1 : 2;
			cl = (cc == 0) ? cen : cen - 1;
			if (dir_reg == DIR_X) begin
				sum = (tap(rt, 2) - tap(rt, cl)) + 2 * (tap(1, 2) - tap(1, cl)) +
					(tap(rb, 2) - tap(rb, cl));
			end else begin
				sum = (tap(rb, cl) - tap(rt, cl)) + 2 * (tap(rb, cen) - tap(rt, cen)) +
					(tap(rb, 2) - tap(rt, 2));
			end
			if (sum < 0) res.grad = 8'd0;
			else if (sum > 255) res.grad = 8'd255;
			else res.grad = pix_t'(sum);
			res.last = (m == side * side - 1);
			emit = 1'b1;
		end
		if (col == 0) shift_column(col, pix);
		raster_pos = (emit && res.last) ? 0 : pos + 1;
		return emit;
	endfunction

	task automatic log_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		gradient_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			window = '0;
			raster_pos = 0;
			side_reg = MAX_WIDTH;
			dir_reg = DIR_X;
			results_seen = 0;
			pending_gradients.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					side_reg = 32'(cfg_data[WID_W-1:0]);
					raster_pos = 0;
				end else if (cfg_index == REG_GRADIENT_DIRECTION) begin
					dir_reg = cfg_data[0];
				end
			end
			// Results are checked before the request of the same edge is predicted.
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_gradients.size() == 0) begin
					log_mismatch($sformatf("unexpected result: gradient %0d last %0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = pending_gradients.pop_front();
					if (m_axis_tdata !== want.grad || m_axis_tlast !== want.last)
						log_mismatch($sformatf({"result %0d: expected gradient %0d",
							" last %0b, got gradient %0d last %0b"},
							results_seen, want.grad, want.last, m_axis_tdata,
							m_axis_tlast));
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (predict_gradient(s_axis_tuser, s_axis_tdata, want))
					pending_gradients = {pending_gradients, want};
			end
			pending_count = pending_gradients.size();
		end
	end

endmodule

[dv/tb_top.sv]
// Testbench top for the Sobel 3x3 gradient filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import s3g_pkg::*;

	// A run with no accepted request, result or register write for this many cycles
	// is hung. The longest legal quiet stretch is a sender gap, a receiver stall or
	// the settle pause.
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	// The directed part already sends about eleven hundred requests.
	localparam int RANDOM_ITEMS = 300;

	// Every input of the block starts at a known value.
	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] pixel_value
	logic s_axis_tuser = OP_PIXEL;   // [0] operation
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;        // [7:0] gradient_value
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	int mismatch_count;
	int pending_count;

	// Sender and receiver pacing state.
	int burst_left = 0;
	int sent_items = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int ready_tick = 0;
	int quiet_cycles = 0;
	logic cur_dir = DIR_X;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	sobel_3x3_gradient_filter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sobel_result_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	// The receiver switches between several stall patterns: always ready, light and
	// heavy random stalls, and a fixed on-off rhythm. Each pattern holds for a random
	// stretch so that back-pressure lands on every phase of a frame.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		ready_tick++;
		case (ready_mode)
			0: begin
				m_axis_tready = 1'b1;
			end
			1: begin
				m_axis_tready = ($urandom_range(0, 3) != 0);
			end
			2: begin
				m_axis_tready = ($urandom_range(0, 1) == 0);
			end
			default: begin
				m_axis_tready = ((ready_tick % 7) < 4);
			end
		endcase
	end

	// The watchdog restarts on any handshake or register write.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Gray levels lean toward black and white so that the clamp is hit at both ends.
	function automatic pix_t pick_pixel();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return pix_t'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// Offers one request and returns after the edge that accepts it. The sender works
	// in bursts; when a burst runs out, valid drops for a random gap first. A gap of
	// zero and the occasional long burst give stretches with no idling at all.
	task automatic send_req(input logic op, input pix_t value);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 16);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = value;
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
	endtask

	// Stops the request stream, waits for every expected result and then lets the
	// pipeline empty out, since requests that make no result may still be in flight.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_up(input int unsigned side_val, input logic dir);
		write_reg(REG_IMAGE_WIDTH, side_val);
		cur_dir = dir;
		write_reg(REG_GRADIENT_DIRECTION, dir);
	endtask

	// Sends one frame of the given side followed by its flush requests. The frame is
	// cut short at stop_at, and at turn_at the stream pauses for a direction flip.
	// Pixels sometimes arrive as drain requests (they count as black), and flush
	// requests sometimes carry pixels.
	task automatic send_frame(input int unsigned side, input int unsigned stop_at,
			input int unsigned turn_at);
		int unsigned span;
		span = side * side + side + 1;
		for (int unsigned i = 0; i < span && i < stop_at; i++) begin
			if (i == turn_at) begin
				settle();
				cur_dir = ~cur_dir;
				write_reg(REG_GRADIENT_DIRECTION, cur_dir);
			end
			if (i < side * side) begin
				send_req(($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_PIXEL, pick_pixel());
			end else begin
				send_req(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN, pick_pixel());
			end
		end
	endtask

	initial begin : stimulus
		int unsigned side;
		int unsigned span;
		int unsigned stop_at;
		int unsigned turn_at;
		int frames;
		int random_base;
		logic restart;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// One-pixel image: a white pixel, a plain flush and a pixel sent as a flush.
		set_up(1, DIR_X);
		send_req(OP_PIXEL, 8'hFF);
		send_req(OP_DRAIN, 8'h00);
		send_req(OP_PIXEL, 8'hA5);
		settle();

		// A width register of zero must behave as a one-pixel image.
		set_up(0, DIR_Y);
		send_frame(1, 3, 3);
		settle();

		// Three-pixel image with a white middle column, so the horizontal gradient
		// saturates high on the left edge and clamps to zero on the right edge. The
		// center arrives as a drain request and must count as black.
		set_up(3, DIR_X);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) send_req(OP_DRAIN, 8'hFF);
			else send_req(OP_PIXEL, (i % 3 == 1) ? 8'hFF : 8'h00);
		end
		for (int i = 0; i < 4; i++) send_req(OP_DRAIN, 8'h00);
		settle();

		// Widest image: a register value above the maximum acts as the maximum. Only
		// the start of the frame is sent, enough for a few dozen top-row results.
		set_up(2047, DIR_Y);
		send_frame(MAX_WIDTH, MAX_WIDTH + 1 + 40, MAX_WIDTH * 2);
		settle();

		// Random frames, mostly small. A phase may run several frames back to back,
		// flip the direction mid-frame, or abort a frame, after which the width is
		// always written again to restart the raster.
		random_base = sent_items;
		restart = 1'b1;
		side = 3;
		while (sent_items - random_base < RANDOM_ITEMS) begin
			if (restart || $urandom_range(0, 3) != 0) begin
				side = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) :
					$urandom_range(1, 12);
				write_reg(REG_IMAGE_WIDTH, side);
				restart = 1'b0;
			end
			if ($urandom_range(0, 1) == 0) begin
				cur_dir = ~cur_dir;
				write_reg(REG_GRADIENT_DIRECTION, cur_dir);
			end
			frames = $urandom_range(1, 3);
			span = side * side + side + 1;
			for (int f = 0; f < frames && !restart &&
					sent_items - random_base < RANDOM_ITEMS; f++) begin
				stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span - 1) : span;
				turn_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, span - 1) : span;
				send_frame(side, stop_at, turn_at);
				restart = (stop_at < span);
			end
			settle();
		end

		// Let any stray result show up before the verdict.
		settle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
src/s3g_pkg.sv
src/s3g_ram.sv
src/s3g_ctl.sv
src/s3g_grad.sv
src/sobel_3x3_gradient_filter.sv
src/s3g_checker.sv
dv/sobel_result_checker.sv
dv/tb_top.sv
